### rtl/core/button_scan_autorepeat_top_defines.svh
// Assertion macros for the button scanner with auto-repeat.
// Included by the top level; needs nothing else.
`ifndef BUTTON_SCAN_AUTOREPEAT_TOP_DEFINES_SVH
`define BUTTON_SCAN_AUTOREPEAT_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BSA_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BSA_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bsa_pkg.sv
// Shared constants, types and register codes of the button scanner.
// Used by bsa_lane and button_scan_autorepeat_top; depends on nothing.
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int TIME_BITS   = 32;

  localparam int MASK_W     = 16;
  localparam int LANES      = (NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W;
  localparam int LANE_IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int COUNT_W    = 5;
  localparam int DELAY_W    = 16;
  localparam int BTN_SEL_W  = 4;

  localparam int IN_TIME_W  = 32;
  localparam int IN_W       = ((IN_TIME_W + MASK_W + 7) / 8) * 8;
  localparam int OUT_FIELDS = 4 * MASK_W + 3;
  localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [DELAY_W-1:0]   delay_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUTTON_COUNT  = 3'd0,
    REG_FIRST_REPEAT  = 3'd1,
    REG_REPEAT_PERIOD = 3'd2,
    REG_LONG_HOLD_MS  = 3'd3,
    REG_LONG_HOLD_EN  = 3'd4,
    REG_LONG_HOLD_BTN = 3'd5,
    REG_FORWARDING    = 3'd6
  } cfg_reg_t;

  // Per-scan control handed to one button lane.
  typedef struct packed {
    logic active;   // button index is below the effective count
    logic update;   // the scan in the input register is being retired
    logic pressed;  // level is low this scan
  } lane_ctrl_t;

  // Per-scan status returned by one button lane.
  typedef struct packed {
    logic was_down;
    logic pe;
    logic re;
    logic hm;
    logic am;
  } lane_stat_t;

endpackage

### rtl/core/bsa_lane.sv
// One button lane: edge detection, held flag and typematic repeat timing.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_lane (
  input  logic               clk,
  input  logic               rst,
  input  bsa_pkg::lane_ctrl_t ctrl,
  input  bsa_pkg::time_t      now,
  input  bsa_pkg::delay_t     first_repeat_ms,
  input  bsa_pkg::delay_t     repeat_period_ms,
  output bsa_pkg::lane_stat_t stat,
  output bsa_pkg::time_t      press_start
);
  import bsa_pkg::*;

  logic  was_down;
  logic  first_pending;
  time_t repeat_mark;

  logic  press_edge, release_edge, hold;
  logic  fire_first, fire_repeat;
  time_t since;
  time_t first_delay, period;

  assign first_delay = time_t'(first_repeat_ms);
  assign period      = time_t'(repeat_period_ms);

  assign press_edge   = !was_down && ctrl.pressed;
  assign release_edge = was_down && !ctrl.pressed;
  assign hold         = was_down && ctrl.pressed;

  // Wrapping difference; the compares below are strict.
  assign since       = now - repeat_mark;
  assign fire_first  = hold && first_pending && (since > first_delay);
  assign fire_repeat = hold && !first_pending && (since > period);

  always_comb begin
    stat.was_down = was_down;
    stat.pe       = ctrl.active && press_edge;
    stat.re       = ctrl.active && release_edge;
    stat.hm       = ctrl.active && ctrl.pressed;
    stat.am       = ctrl.active && (press_edge || fire_first || fire_repeat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_down      <= 1'b0;
      first_pending <= 1'b0;
    end else if (ctrl.update && ctrl.active) begin
      was_down <= ctrl.pressed;
      if (press_edge) begin
        first_pending <= 1'b1;
      end else if (fire_first) begin
        first_pending <= 1'b0;
      end
    end
  end

  // A press sets the mark to the current time; after that it steps by the delay or period, never to the current time.
  always_ff @(posedge clk) begin
    if (ctrl.update && ctrl.active) begin
      if (press_edge) begin
        repeat_mark <= now;
        press_start <= now;
      end else if (fire_first) begin
        repeat_mark <= repeat_mark + first_delay;
      end else if (fire_repeat) begin
        repeat_mark <= repeat_mark + period;
      end
    end
  end

endmodule

### rtl/core/button_scan_autorepeat_top.sv
// Channel  Dir  Beat content (low bits first)
// s_*      in   time_ms[31:0], raw_levels[47:32], zero pad to 48
// m_*      out  pressed, released, held, activated masks, wake, long-hold flags
// cfg_*    in   register index and 16-bit write data
//
// One scan enters the input register, is evaluated by all button lanes in
// parallel and lands in the output register; one scan per cycle is sustained
// while the output is not stalled. The lane state updates when a scan
// moves to the output register, so each scan sees the state its predecessor
// left. Synchronous reset clears the handshake state, the pressed and
// first-repeat flags and the registers to their defaults; no sweep is needed.
// A stalled output holds its beat; the input register still takes one beat.
// Depends on bsa_pkg, bsa_lane and button_scan_autorepeat_top_defines.svh.
`timescale 1ns / 1ps
`include "button_scan_autorepeat_top_defines.svh"

module button_scan_autorepeat_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bsa_pkg::IN_W-1:0]       s_tdata,   // time_ms, raw_levels
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bsa_pkg::OUT_W-1:0]      m_tdata,   // pressed_edges, released_edges,
                                                    // held_mask, activated_mask, wake,
                                                    // long_hold_active, long_hold_released
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bsa_pkg::*;

  // Configuration registers.
  logic [COUNT_W-1:0]   button_count;
  delay_t               first_repeat_ms;
  delay_t               repeat_period_ms;
  delay_t               long_hold_ms;
  logic                 long_hold_enable;
  logic [BTN_SEL_W-1:0] long_hold_button;
  logic                 forwarding_enabled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_count       <= COUNT_W'(10);
      first_repeat_ms    <= DELAY_W'(500);
      repeat_period_ms   <= DELAY_W'(100);
      long_hold_ms       <= DELAY_W'(1000);
      long_hold_enable   <= 1'b0;
      long_hold_button   <= '0;
      forwarding_enabled <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BUTTON_COUNT:  button_count       <= cfg_data[COUNT_W-1:0];
        REG_FIRST_REPEAT:  first_repeat_ms    <= cfg_data[DELAY_W-1:0];
        REG_REPEAT_PERIOD: repeat_period_ms   <= cfg_data[DELAY_W-1:0];
        REG_LONG_HOLD_MS:  long_hold_ms       <= cfg_data[DELAY_W-1:0];
        REG_LONG_HOLD_EN:  long_hold_enable   <= cfg_data[0];
        REG_LONG_HOLD_BTN: long_hold_button   <= cfg_data[BTN_SEL_W-1:0];
        REG_FORWARDING:    forwarding_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic                in_valid;
  logic [IN_W-1:0]     in_data;
  logic                advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
    end
  end

  time_t             now;
  logic [MASK_W-1:0] levels;
  logic [COUNT_W-1:0] eff_count;

  assign now    = time_t'(in_data[IN_TIME_W-1:0]);
  assign levels = in_data[IN_TIME_W +: MASK_W];

  // Effective count saturates at the number of lanes.
  assign eff_count = (button_count > COUNT_W'(LANES)) ? COUNT_W'(LANES) : button_count;

  lane_ctrl_t lane_ctrl   [LANES];
  lane_stat_t lane_stat   [LANES];
  time_t      lane_start  [LANES];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    assign lane_ctrl[g].active  = COUNT_W'(g) < eff_count;
    assign lane_ctrl[g].update  = advance;
    assign lane_ctrl[g].pressed = !levels[g];

    bsa_lane u_lane (
      .clk              (clk),
      .rst              (rst),
      .ctrl             (lane_ctrl[g]),
      .now              (now),
      .first_repeat_ms  (first_repeat_ms),
      .repeat_period_ms (repeat_period_ms),
      .stat             (lane_stat[g]),
      .press_start      (lane_start[g])
    );
  end

  logic [MASK_W-1:0] pe_vec, re_vec, hm_vec, am_vec;

  always_comb begin
    pe_vec = '0;
    re_vec = '0;
    hm_vec = '0;
    am_vec = '0;
    for (int i = 0; i < LANES; i++) begin
      pe_vec[i] = lane_stat[i].pe;
      re_vec[i] = lane_stat[i].re;
      hm_vec[i] = lane_stat[i].hm;
      am_vec[i] = lane_stat[i].am;
    end
  end

  // Long hold on the watched button: one shared subtract and compare.
  logic                  watched;
  logic [LANE_IDX_W-1:0] watch_idx;
  logic                  watch_was_down;
  logic                  watch_pressed;
  time_t                 hold_time;
  logic                  held_long;
  logic                  lh_active, lh_released;

  assign watched        = long_hold_enable && (COUNT_W'(long_hold_button) < eff_count);
  assign watch_idx      = long_hold_button[LANE_IDX_W-1:0];
  assign watch_was_down = lane_stat[watch_idx].was_down;
  assign watch_pressed  = !levels[long_hold_button];
  assign hold_time      = now - lane_start[watch_idx];
  assign held_long      = hold_time > time_t'(long_hold_ms);
  assign lh_active      = watched && watch_was_down && watch_pressed && held_long;
  assign lh_released    = watched && watch_was_down && !watch_pressed && held_long;

  logic [MASK_W-1:0] fwd_mask;
  logic [OUT_W-1:0]  out_next;

  assign fwd_mask = {MASK_W{forwarding_enabled}};
  assign out_next = OUT_W'({lh_released, lh_active, |pe_vec,
                            am_vec & fwd_mask, hm_vec & fwd_mask,
                            re_vec & fwd_mask, pe_vec & fwd_mask});

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= out_next;
    end
  end

  // A released button cannot be counted as held in the same scan.
  `BSA_ASSERT_NOW(a_release_not_held, clk, rst, m_tvalid,
    (m_tdata[MASK_W +: MASK_W] & m_tdata[2*MASK_W +: MASK_W]) == '0,
    "release edge reported on a held button")
  // Every press edge is also an activation.
  `BSA_ASSERT_NOW(a_press_activates, clk, rst, m_tvalid,
    (m_tdata[0 +: MASK_W] & ~m_tdata[3*MASK_W +: MASK_W]) == '0,
    "press edge without activation")
  // Both long-hold flags can never be raised for one scan.
  `BSA_ASSERT_NOW(a_long_hold_excl, clk, rst, m_tvalid,
    !(m_tdata[4*MASK_W+1] && m_tdata[4*MASK_W+2]),
    "long hold active and released together")
  // A scan waiting in the input register is never dropped.
  `BSA_ASSERT_NEXT(a_input_kept, clk, rst, in_valid && !advance,
    in_valid,
    "pending scan lost from input register")

endmodule

### tb/button_scan_autorepeat_top_tb.sv
// Self-checking bench for button_scan_autorepeat_top: a directed table, then random scan runs.
// Every accepted scan is predicted in the bench and compared with the next output beat.
// Depends on bsa_pkg and button_scan_autorepeat_top.
`timescale 1ns / 1ps

module button_scan_autorepeat_top_tb;
  import bsa_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASES       = 6;
  localparam int PHASE_SCANS  = 225;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_CYCLES = 400;
  localparam int MAX_REPORTS  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // index past the register list

  localparam logic [4:0] DEF_COUNT  = 5'd10;
  localparam delay_t     DEF_FIRST  = 16'd500;
  localparam delay_t     DEF_PERIOD = 16'd100;
  localparam delay_t     DEF_HOLD   = 16'd1000;

  typedef struct packed {
    logic [15:0] pe;
    logic [15:0] re;
    logic [15:0] hm;
    logic [15:0] am;
    logic        wake;
    logic        lha;
    logic        lhr;
  } scan_res_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
    time_t                t;
    logic [15:0]          lv;
    bit                   typed;
    scan_res_t            want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  button_scan_autorepeat_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register shadow and per-button state of the scanner.
  logic [4:0] btn_count_q = DEF_COUNT;
  delay_t     first_dly_q = DEF_FIRST;
  delay_t     period_q    = DEF_PERIOD;
  delay_t     hold_ms_q   = DEF_HOLD;
  logic       hold_en_q   = 1'b0;
  logic [3:0] hold_btn_q  = 4'd0;
  logic       fwd_q       = 1'b1;
  logic       down_q  [16] = '{default: 1'b0};
  logic       first_q [16] = '{default: 1'b0};
  time_t      mark_q  [16] = '{default: '0};
  time_t      start_q [16] = '{default: '0};

  scan_res_t  pending_scans[$];
  int         mismatches = 0;
  int         scans_out = 0;
  int         cycles = 0;

  bit         drv_typed = 1'b0;
  scan_res_t  drv_want = '0;
  bit         tx_steady = 1'b0;
  bit         rx_steady = 1'b0;
  int         hold_req = 0;

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    case (idx)
      REG_BUTTON_COUNT:  btn_count_q = data[4:0];
      REG_FIRST_REPEAT:  first_dly_q = data;
      REG_REPEAT_PERIOD: period_q    = data;
      REG_LONG_HOLD_MS:  hold_ms_q   = data;
      REG_LONG_HOLD_EN:  hold_en_q   = data[0];
      REG_LONG_HOLD_BTN: hold_btn_q  = data[3:0];
      REG_FORWARDING:    fwd_q       = data[0];
      default: ;
    endcase
  endfunction

  function automatic scan_res_t scan_predict(input time_t now, input logic [15:0] lv);
    scan_res_t r;
    int        n;
    int        i;
    logic      pr;
    logic      watched;
    time_t     since;
    time_t     held_for;
    r = '0;
    n = (btn_count_q > LANES) ? LANES : btn_count_q;
    for (i = 0; i < n; i++) begin
      pr = !lv[i];
      watched = hold_en_q && (hold_btn_q == i);
      held_for = now - start_q[i];
      if (!down_q[i] && pr) begin
        r.pe[i] = 1'b1;
        r.am[i] = 1'b1;
        r.hm[i] = 1'b1;
        mark_q[i] = now;
        start_q[i] = now;
        first_q[i] = 1'b1;
      end else if (down_q[i] && !pr) begin
        r.re[i] = 1'b1;
        if (watched && held_for > hold_ms_q) r.lhr = 1'b1;
      end else if (down_q[i] && pr) begin
        since = now - mark_q[i];
        r.hm[i] = 1'b1;
        // The mark moves by the delay or period, so late scans catch up one step at a time.
        if (first_q[i]) begin
          if (since > first_dly_q) begin
            r.am[i] = 1'b1;
            mark_q[i] = mark_q[i] + first_dly_q;
            first_q[i] = 1'b0;
          end
        end else if (since > period_q) begin
          r.am[i] = 1'b1;
          mark_q[i] = mark_q[i] + period_q;
        end
        if (watched && held_for > hold_ms_q) r.lha = 1'b1;
      end
      down_q[i] = pr;
    end
    r.wake = |r.pe;
    if (!fwd_q) begin
      r.pe = '0;
      r.re = '0;
      r.hm = '0;
      r.am = '0;
    end
    return r;
  endfunction

  // Output check, then shadow updates for whatever was accepted at this edge.
  always @(posedge clk) begin
    scan_res_t got;
    scan_res_t want;
    scan_res_t next;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("button_scan_autorepeat_top: mismatch");
      $finish;
    end else if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.pe   = m_tdata[15:0];
        got.re   = m_tdata[31:16];
        got.hm   = m_tdata[47:32];
        got.am   = m_tdata[63:48];
        got.wake = m_tdata[64];
        got.lha  = m_tdata[65];
        got.lhr  = m_tdata[66];
        if (pending_scans.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result beat %0d arrived with no scan pending: %h", scans_out, m_tdata);
        end else begin
          want = pending_scans.pop_front();
          if (got.pe !== want.pe || got.re !== want.re || got.hm !== want.hm ||
              got.am !== want.am || got.wake !== want.wake || got.lha !== want.lha ||
              got.lhr !== want.lhr) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("beat %0d want pe=%h re=%h hm=%h am=%h wake=%b lha=%b lhr=%b",
                       scans_out, want.pe, want.re, want.hm, want.am, want.wake, want.lha,
                       want.lhr);
              $display("beat %0d got  pe=%h re=%h hm=%h am=%h wake=%b lha=%b lhr=%b",
                       scans_out, got.pe, got.re, got.hm, got.am, got.wake, got.lha, got.lhr);
            end
          end
        end
        scans_out++;
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        next = scan_predict(s_tdata[31:0], s_tdata[47:32]);
        if (drv_typed) next = drv_want;
        pending_scans.push_back(next);
      end
    end
  end

  // Result side: random back-pressure, a long hold-off on request, none in steady phases.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = rx_steady || ($urandom_range(99) >= 24);
      end
    end
  end

  // Leaves tvalid high after the beat so a following scan needs no low-high toggle.
  task automatic send_scan(input time_t t, input logic [15:0] lv, input bit typed,
                           input scan_res_t want);
    cfg_valid = 1'b0;
    while (!tx_steady && $urandom_range(99) < 24) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = {lv, t};
    drv_typed = typed;
    drv_want = want;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    s_tvalid = 1'b0;
    while (pending_scans.size() != 0) @(negedge clk);
    while (!tx_steady && $urandom_range(99) < 24) begin
      cfg_valid = 1'b0;
      @(negedge clk);
    end
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] with_junk(input logic [15:0] val, input int width,
                                            input bit junk);
    logic [15:0] rnd;
    rnd = $urandom;
    if (junk && width < 16) return val | (rnd << width);
    return val;
  endfunction

  task automatic set_regs(input logic [4:0] count, input delay_t first, input delay_t period,
                          input delay_t hold, input logic en, input logic [3:0] btn,
                          input logic fwd, input bit junk);
    cfg_write(REG_BUTTON_COUNT,  with_junk(16'(count), 5, junk));
    cfg_write(REG_FIRST_REPEAT,  first);
    cfg_write(REG_REPEAT_PERIOD, period);
    cfg_write(REG_LONG_HOLD_MS,  hold);
    cfg_write(REG_LONG_HOLD_EN,  with_junk(16'(en), 1, junk));
    cfg_write(REG_LONG_HOLD_BTN, with_junk(16'(btn), 4, junk));
    cfg_write(REG_FORWARDING,    with_junk(16'(fwd), 1, junk));
  endtask

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic row_t scan_row(input time_t t, input logic [15:0] lv);
    row_t r;
    r = '{default: '0};
    r.t = t;
    r.lv = lv;
    return r;
  endfunction

  function automatic row_t typed_row(input time_t t, input logic [15:0] lv,
                                     input logic [15:0] pe, input logic [15:0] re,
                                     input logic [15:0] hm, input logic [15:0] am,
                                     input logic wake, input logic lha, input logic lhr);
    row_t r;
    r = scan_row(t, lv);
    r.typed = 1'b1;
    r.want = '{pe: pe, re: re, hm: hm, am: am, wake: wake, lha: lha, lhr: lhr};
    return r;
  endfunction

  initial begin
    row_t        dir_rows[$];
    time_t       now;
    time_t       delta;
    logic [15:0] lv;
    int          r;
    int          b;
    int          p;
    int          k;

    // Defaults: ten buttons, 500 ms first repeat, 100 ms period, long hold off.
    dir_rows.push_back(typed_row(32'd0,   16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(typed_row(32'd0,   16'h0000, 16'h03FF, 0, 16'h03FF, 16'h03FF, 1, 0, 0));
    dir_rows.push_back(typed_row(32'd500, 16'h0000, 0, 0, 16'h03FF, 0, 0, 0, 0));
    dir_rows.push_back(typed_row(32'd501, 16'h0000, 0, 0, 16'h03FF, 16'h03FF, 0, 0, 0));
    dir_rows.push_back(typed_row(32'd600, 16'h0000, 0, 0, 16'h03FF, 0, 0, 0, 0));
    dir_rows.push_back(typed_row(32'd601, 16'h0000, 0, 0, 16'h03FF, 16'h03FF, 0, 0, 0));
    dir_rows.push_back(typed_row(32'd602, 16'hFFFF, 0, 16'h03FF, 0, 0, 0, 0, 0));
    // A count above the lane limit saturates; watch the top button for a long hold.
    dir_rows.push_back(cfg_row(REG_BUTTON_COUNT, 16'd31));
    dir_rows.push_back(cfg_row(REG_LONG_HOLD_EN, 16'd1));
    dir_rows.push_back(cfg_row(REG_LONG_HOLD_BTN, 16'd15));
    dir_rows.push_back(typed_row(32'd1000, 16'h7FFF, 16'h8000, 0, 16'h8000, 16'h8000, 1, 0, 0));
    dir_rows.push_back(typed_row(32'd2000, 16'h7FFF, 0, 0, 16'h8000, 16'h8000, 0, 0, 0));
    dir_rows.push_back(typed_row(32'd2001, 16'h7FFF, 0, 0, 16'h8000, 16'h8000, 0, 1, 0));
    dir_rows.push_back(typed_row(32'd2002, 16'hFFFF, 0, 16'h8000, 0, 0, 0, 0, 1));
    // Forwarding off hides the masks but not wake.
    dir_rows.push_back(cfg_row(REG_FORWARDING, 16'd0));
    dir_rows.push_back(typed_row(32'd3000, 16'h0000, 0, 0, 0, 0, 1, 0, 0));
    dir_rows.push_back(typed_row(32'd3001, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
    // Zero delays and a press just before the time stamp wraps.
    dir_rows.push_back(cfg_row(REG_FORWARDING, 16'd1));
    dir_rows.push_back(cfg_row(REG_FIRST_REPEAT, 16'd0));
    dir_rows.push_back(cfg_row(REG_REPEAT_PERIOD, 16'd0));
    dir_rows.push_back(cfg_row(REG_LONG_HOLD_MS, 16'd0));
    dir_rows.push_back(typed_row(32'hFFFF_FFFE, 16'hFFFE, 16'h0001, 0, 16'h0001, 16'h0001,
                                 1, 0, 0));
    dir_rows.push_back(typed_row(32'hFFFF_FFFE, 16'hFFFE, 0, 0, 16'h0001, 0, 0, 0, 0));
    dir_rows.push_back(typed_row(32'h0000_0001, 16'hFFFE, 0, 0, 16'h0001, 16'h0001, 0, 0, 0));
    dir_rows.push_back(scan_row(32'h0000_0001, 16'hFFFE));
    // No buttons in use: everything reads zero and the state stays frozen.
    dir_rows.push_back(cfg_row(REG_BUTTON_COUNT, 16'd0));
    dir_rows.push_back(typed_row(32'd5, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(REG_BUTTON_COUNT, 16'd1));
    dir_rows.push_back(cfg_row(REG_LONG_HOLD_BTN, 16'd0));
    dir_rows.push_back(scan_row(32'd6, 16'h0000));
    dir_rows.push_back(scan_row(32'd7, 16'hFFFF));
    // Unknown index is ignored; a watched button past the count gives no flags.
    dir_rows.push_back(cfg_row(REG_NONE, 16'hFFFF));
    dir_rows.push_back(cfg_row(REG_LONG_HOLD_BTN, 16'd5));
    dir_rows.push_back(scan_row(32'd8, 16'h0000));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) cfg_write(dir_rows[k].idx, dir_rows[k].data);
      else send_scan(dir_rows[k].t, dir_rows[k].lv, dir_rows[k].typed, dir_rows[k].want);
    end

    lv = 16'hFFFF;
    now = 32'd10000;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: set_regs(5'd16, 16'd20, 16'd5, 16'd60, 1'b1, 4'd3, 1'b1, 1'b0);
        1: set_regs(5'd31, 16'd0, 16'd0, 16'd0, 1'b1, 4'd15, 1'b1, 1'b0);
        2: set_regs(5'd16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 4'd0, 1'b1, 1'b0);
        3: set_regs(5'd16, 16'd50, 16'd10, 16'd200, 1'b1, 4'($urandom_range(15)), 1'b1,
                    1'b1);
        4: set_regs(5'd1, 16'd8, 16'd3, 16'd30, 1'b1, 4'd0, 1'b0, 1'b1);
        default: set_regs(5'($urandom_range(31)), 16'($urandom_range(300)),
                          16'($urandom_range(60)), 16'($urandom_range(1500)),
                          1'($urandom_range(1)), 4'($urandom_range(15)),
                          1'($urandom_range(1)), 1'b1);
      endcase
      if (p == 2) now = 32'hFFFF_0000;
      tx_steady = (p == 3);
      rx_steady = (p == 3);
      if (p == 1) hold_req = STALL_CYCLES;
      for (k = 0; k < PHASE_SCANS; k++) begin
        r = $urandom_range(99);
        if (r < 70) delta = $urandom_range(30);
        else if (r < 90) delta = $urandom_range(1200);
        else if (r < 98) delta = $urandom_range(70000);
        else delta = $urandom;
        now = now + delta;
        // Mostly slow-moving buttons so that holds last long enough to repeat.
        if ($urandom_range(99) < 5) begin
          lv = $urandom;
        end else begin
          for (b = 0; b < 16; b++)
            if ($urandom_range(15) == 0) lv[b] = ~lv[b];
        end
        send_scan(now, lv, 1'b0, '0);
      end
    end

    s_tvalid = 1'b0;
    cfg_valid = 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    while (pending_scans.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("button_scan_autorepeat_top: match");
    end else begin
      $display("button_scan_autorepeat_top: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/bsa_pkg.sv
rtl/core/bsa_lane.sv
rtl/core/button_scan_autorepeat_top.sv
tb/button_scan_autorepeat_top_tb.sv
